// ----- rtl/core/spwa_pkg.sv -----
// Shared types, constants and coefficient table for the sine power window block.
package spwa_pkg;

   localparam int MAX_LOG2_HALF_DEF = 16;
   localparam int LG_W              = 5;
   localparam int DATA_W            = 24;
   localparam int GAIN_W            = 24;
   localparam int X_W               = 31;
   localparam int MUL_W             = 32;
   localparam int PROD_W            = 64;
   localparam int Q_FRAC            = 30;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 24;
   localparam int STEP_W            = 3;

   localparam logic [X_W-1:0]    Q30_ONE     = X_W'(1) << Q_FRAC;
   localparam logic [X_W-1:0]    SC13        = X_W'(61);
   localparam logic [STEP_W-1:0] HORNER_LAST = STEP_W'(5);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_HALF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 2'd2;

   localparam logic [1:0] WT_SINE        = 2'd0;
   localparam logic [1:0] WT_SINE_SQ     = 2'd1;
   localparam logic [1:0] WT_SINE_SINE   = 2'd2;
   localparam logic [1:0] WT_SINE_SINE_SQ = 2'd3;

   localparam logic [LG_W-1:0] LOG2_HALF_RESET = LG_W'(8);
   localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic signed [GAIN_W-1:0] gain;
      logic [1:0]               wtype;
      logic [X_W-1:0]           x;
      logic                     last;
   } spwa_job_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } spwa_result_type;

   function automatic logic [X_W-1:0] horner_coef(input logic [STEP_W-1:0] step);
      logic [X_W-1:0] c;
      case (step)
         3'd0:    c = X_W'(3864);
         3'd1:    c = X_W'(172272);
         3'd2:    c = X_W'(5026995);
         3'd3:    c = X_W'(85569306);
         3'd4:    c = X_W'(693598668);
         3'd5:    c = X_W'(1686629713);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/spwa_if.sv -----
// Valid/ready channel interfaces for sample, result and register-write words.
interface spwa_req_if
   import spwa_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;
   logic                     frame_start;
   modport source (output valid, output sample, output frame_start, input ready);
   modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface spwa_rsp_if
   import spwa_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] windowed_sample;
   logic                     last_in_frame;
   modport source (output valid, output windowed_sample, output last_in_frame, input ready);
   modport sink (input valid, input windowed_sample, input last_in_frame, output ready);
endinterface

interface spwa_csr_if
   import spwa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/spwa_mul.sv -----
// Shared signed multiplier with registered product.
module spwa_mul
   import spwa_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  a,
   input  logic signed [MUL_W-1:0]  b,
   output logic signed [PROD_W-1:0] p_ff
);

   logic signed [PROD_W-1:0] p_in;

   assign p_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ----- rtl/core/spwa_seq.sv -----
// Sequencer that runs sine polynomial, squaring and scaling through one multiplier.
module spwa_seq
   import spwa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  spwa_job_type    job,
   output logic            ready,
   output logic            done,
   input  logic            take,
   output spwa_result_type result
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQX, ST_HORN, ST_SFIN, ST_SQW, ST_SCALE, ST_GAIN, ST_DONE
   } state_type;

   localparam int SCL_W = DATA_W + 1;
   localparam int GSH_W = PROD_W - 16;
   localparam logic signed [PROD_W-1:0] RND_SCALE = PROD_W'(1) << 22;
   localparam logic signed [PROD_W-1:0] RND_GAIN  = PROD_W'(1) << 15;
   localparam logic signed [GSH_W-1:0]  SAT_MAX   = GSH_W'(8388607);
   localparam logic signed [GSH_W-1:0]  SAT_MIN   = -GSH_W'(8388608);

   state_type                state_ff;
   logic                     phase_ff;
   logic                     pass_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [X_W-1:0]           x_ff;
   logic [X_W-1:0]           x2_ff;
   logic [X_W-1:0]           t_ff;
   logic [X_W-1:0]           w_ff;
   logic signed [DATA_W-1:0] sample_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [1:0]               wtype_ff;
   logic                     last_ff;
   logic signed [SCL_W-1:0]  scaled_ff;
   spwa_result_type          result_ff;

   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [X_W-1:0]           hi30;
   logic [X_W-1:0]           sine_clamp;
   logic [X_W-1:0]           w_rnd;
   logic signed [PROD_W-1:0] scale_sum;
   logic signed [PROD_W-1:0] gain_sum;
   logic signed [GSH_W-1:0]  gain_sh;
   logic signed [DATA_W-1:0] gain_sat;
   logic                     sine_then_square;

   spwa_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (mul_p)
   );

   assign w_rnd = w_ff + X_W'(64);

   always_comb begin
      unique case (state_ff)
         ST_SQX: begin
            mul_a = signed'({1'b0, x_ff});
            mul_b = signed'({1'b0, x_ff});
         end
         ST_HORN: begin
            mul_a = signed'({1'b0, x2_ff});
            mul_b = signed'({1'b0, t_ff});
         end
         ST_SFIN: begin
            mul_a = signed'({1'b0, x_ff});
            mul_b = signed'({1'b0, t_ff});
         end
         ST_SQW: begin
            mul_a = signed'({1'b0, w_ff});
            mul_b = signed'({1'b0, w_ff});
         end
         ST_SCALE: begin
            mul_a = MUL_W'(sample_ff);
            mul_b = signed'({8'b0, w_rnd[X_W-1:7]});
         end
         ST_GAIN: begin
            mul_a = MUL_W'(scaled_ff);
            mul_b = MUL_W'(gain_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign hi30       = mul_p[Q_FRAC+X_W-1:Q_FRAC];
   assign sine_clamp = (hi30 > Q30_ONE) ? Q30_ONE : hi30;
   assign scale_sum  = mul_p + RND_SCALE;
   assign gain_sum   = mul_p + RND_GAIN;
   assign gain_sh    = gain_sum[PROD_W-1:16];
   assign gain_sat   = (gain_sh > SAT_MAX) ? SAT_MAX[DATA_W-1:0] :
                       (gain_sh < SAT_MIN) ? SAT_MIN[DATA_W-1:0] : gain_sh[DATA_W-1:0];
   assign sine_then_square = pass_ff ? (wtype_ff >= WT_SINE_SINE_SQ) : (wtype_ff >= WT_SINE_SQ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  sample_ff <= job.sample;
                  gain_ff   <= job.gain;
                  wtype_ff  <= job.wtype;
                  last_ff   <= job.last;
                  x_ff      <= job.x;
                  pass_ff   <= 1'b0;
                  phase_ff  <= 1'b0;
                  state_ff  <= ST_SQX;
               end
            end
            ST_DONE: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  case (state_ff)
                     ST_SQX: begin
                        x2_ff    <= hi30;
                        t_ff     <= SC13;
                        step_ff  <= '0;
                        state_ff <= ST_HORN;
                     end
                     ST_HORN: begin
                        t_ff <= horner_coef(step_ff) - hi30;
                        if (step_ff == HORNER_LAST) begin
                           state_ff <= ST_SFIN;
                        end else begin
                           step_ff <= step_ff + STEP_W'(1);
                        end
                     end
                     ST_SFIN: begin
                        w_ff     <= sine_clamp;
                        state_ff <= sine_then_square ? ST_SQW : ST_SCALE;
                     end
                     ST_SQW: begin
                        w_ff <= hi30;
                        if (!pass_ff && wtype_ff >= WT_SINE_SINE) begin
                           x_ff     <= hi30;
                           pass_ff  <= 1'b1;
                           state_ff <= ST_SQX;
                        end else begin
                           state_ff <= ST_SCALE;
                        end
                     end
                     ST_SCALE: begin
                        scaled_ff <= scale_sum[SCL_W+22:23];
                        state_ff  <= ST_GAIN;
                     end
                     ST_GAIN: begin
                        result_ff.value <= gain_sat;
                        result_ff.last  <= last_ff;
                        state_ff        <= ST_DONE;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   assign ready  = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_DONE);
   assign result = result_ff;

endmodule

// ----- rtl/core/sine_power_window_apply.sv -----
// Top level of the sine power window: registers, frame position and result word register.
// Each sample word is multiplied by a sine-family window coefficient and a signed Q8.16
// gain and saturated to Q1.23. One shared 32x32 multiplier does all the arithmetic, each
// product registered before use, so a word is busy in the core for one sine pass with
// window type 0, a sine pass and a squaring with type 1, two sine passes with a squaring
// between with type 2 and a further squaring with type 3, then sample and gain scaling,
// then the hand-off of the result to the output register and rearm for the next sample.
// A new sample is taken once the core has handed its result to the output register,
// even while that result still waits on the result channel. Register writes apply to
// the next sample and do not reset the frame position.
module sine_power_window_apply
   import spwa_pkg::*;
#(
   parameter int MAX_LOG2_HALF = MAX_LOG2_HALF_DEF
) (
   input  logic       clock,
   input  logic       reset,
   spwa_req_if.sink   req_ch,
   spwa_rsp_if.source rsp_ch,
   spwa_csr_if.sink   csr_ch
);

   localparam int PW = MAX_LOG2_HALF + 2;

   logic [1:0]               wtype_ff;
   logic [LG_W-1:0]          lg_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [PW-2:0]            pos_ff;
   logic [PW-2:0]            pos_in;
   logic                     rsp_valid_ff;
   spwa_result_type          rsp_data_ff;

   logic [LG_W-1:0] lg_eff;
   logic [PW-1:0]   half;
   logic [PW-1:0]   frame;
   logic [PW-1:0]   pos_ext;
   logic [PW-1:0]   p;
   logic [PW-1:0]   p_next;
   logic [PW-1:0]   idx;
   logic            req_acc;
   logic            seq_ready;
   logic            seq_done;
   logic            seq_take;
   spwa_job_type    job;
   spwa_result_type seq_result;

   assign lg_eff  = (lg_ff > LG_W'(MAX_LOG2_HALF)) ? LG_W'(MAX_LOG2_HALF) : lg_ff;
   assign half    = PW'(1) << lg_eff;
   assign frame   = half << 1;
   assign pos_ext = PW'(pos_ff);
   assign p       = (req_ch.frame_start || pos_ext >= frame) ? '0 : pos_ext;
   assign idx     = (p <= half) ? p : frame - p;
   assign p_next  = p + PW'(1);
   assign pos_in  = (p_next >= frame) ? '0 : p_next[PW-2:0];

   assign job.sample = req_ch.sample;
   assign job.gain   = gain_ff;
   assign job.wtype  = wtype_ff;
   assign job.x      = X_W'(idx) << (LG_W'(Q_FRAC) - lg_eff);
   assign job.last   = (p == frame - PW'(1));

   assign req_ch.ready = seq_ready;
   assign req_acc      = req_ch.valid && seq_ready;
   assign csr_ch.ready = 1'b1;
   assign seq_take     = seq_done && (!rsp_valid_ff || rsp_ch.ready);

   spwa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (req_acc),
      .job    (job),
      .ready  (seq_ready),
      .done   (seq_done),
      .take   (seq_take),
      .result (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wtype_ff     <= WT_SINE;
         lg_ff        <= LOG2_HALF_RESET;
         gain_ff      <= GAIN_RESET;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_WINDOW_TYPE: wtype_ff <= csr_ch.data[1:0];
               CSR_LOG2_HALF:   lg_ff    <= csr_ch.data[LG_W-1:0];
               CSR_GAIN:        gain_ff  <= signed'(csr_ch.data[GAIN_W-1:0]);
               default: begin
               end
            endcase
         end
         if (req_acc) begin
            pos_ff <= pos_in;
         end
         if (seq_take) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= seq_result;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.windowed_sample = rsp_data_ff.value;
   assign rsp_ch.last_in_frame   = rsp_data_ff.last;

endmodule

// ----- rtl/core/spwa_check.sv -----
// Port-level checker for the sine power window, bound to the top level.
module spwa_check
   import spwa_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_windowed_sample
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_windowed_sample))
      else $error("result word dropped or changed while stalled");

   // drop ready while a sample word is in the core
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("second sample word taken while core busy");

   // advance no result right after a sample word enters an empty block
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("result word appeared too early");

   // hold off new results while the core stands idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word appeared while core idle");

endmodule

bind sine_power_window_apply spwa_check u_spwa_check (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_windowed_sample (rsp_ch.windowed_sample)
);

// ----- tb/tb.sv -----
// Self-checking testbench for sine_power_window_apply against a bit-exact window predictor.
`timescale 1ns / 100ps

module tb;
   import spwa_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_TARGET = 1850;
   localparam int LONG_HOLD     = 600;
   localparam int END_SETTLE    = 60;

   localparam logic [CSR_IDX_W-1:0]     CSR_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 24'sh7FFFFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN   = 24'sh800000;
   localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 24'sh010000;

   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned SIN_C1  = 64'd1686629713;
   localparam longint unsigned SIN_C3  = 64'd693598668;
   localparam longint unsigned SIN_C5  = 64'd85569306;
   localparam longint unsigned SIN_C7  = 64'd5026995;
   localparam longint unsigned SIN_C9  = 64'd172272;
   localparam longint unsigned SIN_C11 = 64'd3864;
   localparam longint unsigned SIN_C13 = 64'd61;

   logic clock;
   logic reset;

   spwa_req_if req_ch ();
   spwa_rsp_if rsp_ch ();
   spwa_csr_if csr_ch ();

   sine_power_window_apply dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // window predictor state
   logic [1:0]               win_type = WT_SINE;
   logic [LG_W-1:0]          win_lg   = LOG2_HALF_RESET;
   logic signed [GAIN_W-1:0] win_gain = GAIN_RESET;
   int unsigned              win_pos  = 0;

   spwa_result_type windowed_q[$];
   spwa_result_type head_word;

   int unsigned cycle_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned words_checked  = 0;
   int unsigned error_count    = 0;
   int unsigned settings_count = 0;
   int unsigned burst_left     = 0;
   bit          gaps_on        = 1'b1;

   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned stretch_left  = 0;
   int unsigned stall_mode    = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic longint unsigned quarter_sine_q30(input longint unsigned x_in);
      longint unsigned xc, x2, acc;
      xc  = (x_in > ONE_Q30) ? ONE_Q30 : x_in;
      x2  = (xc * xc) >> 30;
      acc = SIN_C13;
      acc = SIN_C11 - ((x2 * acc) >> 30);
      acc = SIN_C9 - ((x2 * acc) >> 30);
      acc = SIN_C7 - ((x2 * acc) >> 30);
      acc = SIN_C5 - ((x2 * acc) >> 30);
      acc = SIN_C3 - ((x2 * acc) >> 30);
      acc = SIN_C1 - ((x2 * acc) >> 30);
      acc = (xc * acc) >> 30;
      return (acc > ONE_Q30) ? ONE_Q30 : acc;
   endfunction

   function automatic longint round_half_up(input longint v, input int unsigned sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic spwa_result_type window_predict(input logic signed [DATA_W-1:0] s,
                                                      input logic fs);
      int unsigned     lg, half_n, frame_n, p, idx;
      longint unsigned w, wq;
      longint          prod, r;
      spwa_result_type res;
      lg      = (win_lg > MAX_LOG2_HALF_DEF) ? MAX_LOG2_HALF_DEF : win_lg;
      half_n  = 1 << lg;
      frame_n = half_n << 1;
      p       = win_pos;
      if (fs || p >= frame_n) p = 0;
      idx = (p <= half_n) ? p : frame_n - p;
      w = quarter_sine_q30(64'(idx) << (Q_FRAC - lg));
      if (win_type >= WT_SINE_SQ) w = (w * w) >> 30;
      if (win_type >= WT_SINE_SINE) w = quarter_sine_q30(w);
      if (win_type >= WT_SINE_SINE_SQ) w = (w * w) >> 30;
      wq   = (w + 64) >> 7;
      prod = round_half_up(longint'(s) * longint'(wq), 23);
      r    = round_half_up(prod * longint'(win_gain), 16);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      res.value = r[DATA_W-1:0];
      res.last  = (p == frame_n - 1);
      p++;
      if (p >= frame_n) p = 0;
      win_pos = p;
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_sample();
      case ($urandom_range(0, 11))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 9))
         0:       return GAIN_MAX;
         1:       return GAIN_MIN;
         2:       return '0;
         3, 4, 5: return GAIN_W'(int'($urandom_range(0, 262144)) - 131072);
         6:       return GAIN_UNITY;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic fs);
      csr_ch.valid       <= 1'b0;
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= s;
      req_ch.frame_start <= fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      windowed_q.push_back(window_predict(s, fs));
      items_sent++;
      if (gaps_on && burst_left == 0) begin
         req_ch.valid       <= 1'b0;
         req_ch.sample      <= DATA_W'($urandom);
         req_ch.frame_start <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 45)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
      end else if (burst_left != 0) begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b0;
      while (windowed_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_TYPE: win_type = d[1:0];
         CSR_LOG2_HALF:   win_lg   = d[LG_W-1:0];
         CSR_GAIN:        win_gain = d;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] wt, input logic [LG_W-1:0] lg,
                             input logic signed [GAIN_W-1:0] g);
      write_reg(CSR_WINDOW_TYPE, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(3)) | CSR_DATA_W'(wt));
      write_reg(CSR_LOG2_HALF, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(31)) | CSR_DATA_W'(lg));
      write_reg(CSR_GAIN, g);
      settings_count++;
   endtask

   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sh555555, 1'b0);
      send_sample(24'shAAAAAA, 1'b0);
      drain_results();
   endtask

   task automatic test_window_types();
      int t;
      for (t = 0; t < 4; t++) begin
         set_config(2'(t), 5'd0, (t < 2) ? GAIN_MAX : GAIN_MIN);
         send_sample(SAMPLE_MAX, 1'b1);
         send_sample(SAMPLE_MIN, 1'b0);
         drain_results();
      end
   endtask

   task automatic test_special_cases();
      int k;
      set_config(WT_SINE_SQ, 5'd20, GAIN_UNITY);
      for (k = 0; k < 5; k++) send_sample(rand_sample(), k == 0);
      drain_results();
      // shrink the frame under the current position
      write_reg(CSR_LOG2_HALF, CSR_DATA_W'(1));
      for (k = 0; k < 3; k++) send_sample(rand_sample(), 1'b0);
      drain_results();
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_reg(CSR_GAIN, 24'shFF0000);
      send_sample(SAMPLE_MAX, 1'b0);
      drain_results();
   endtask

   task automatic test_backpressure();
      int k;
      set_config(WT_SINE_SINE_SQ, 5'd2, rand_gain());
      gaps_on = 1'b0;
      hold_requests <= hold_requests + 1;
      for (k = 0; k < 24; k++) send_sample(rand_sample(), k == 0);
      gaps_on = 1'b1;
      drain_results();
   endtask

   task automatic test_random_frames();
      int unsigned      n_items, k;
      logic [1:0]       wt;
      logic [LG_W-1:0]  lg;
      logic             fs;
      bit               free_run;
      while (items_sent < RANDOM_TARGET) begin
         drain_results();
         wt = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: lg = LG_W'($urandom_range(0, 4));
            6, 7:             lg = LG_W'($urandom_range(5, 10));
            8:                lg = LG_W'(MAX_LOG2_HALF_DEF);
            default:          lg = LG_W'($urandom_range(17, 31));
         endcase
         if ($urandom_range(0, 3) != 0) begin
            set_config(wt, lg, rand_gain());
         end else begin
            if ($urandom_range(0, 1)) write_reg(CSR_WINDOW_TYPE, CSR_DATA_W'(wt));
            if ($urandom_range(0, 1)) write_reg(CSR_LOG2_HALF, CSR_DATA_W'(lg));
            if ($urandom_range(0, 1)) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
            settings_count++;
         end
         free_run = ($urandom_range(0, 9) == 0);
         n_items  = $urandom_range(30, 90);
         for (k = 0; k < n_items; k++) begin
            if (free_run) fs = 1'($urandom_range(0, 1));
            else if (win_pos == 0) fs = ($urandom_range(0, 9) != 0);
            else fs = ($urandom_range(0, 19) == 0);
            send_sample(rand_sample(), fs);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (windowed_q.size() == 0) begin
               $error("result word with nothing expected: windowed_sample %0d last_in_frame %0b",
                      rsp_ch.windowed_sample, rsp_ch.last_in_frame);
               error_count++;
            end else begin
               head_word = windowed_q.pop_front();
               if (rsp_ch.windowed_sample !== head_word.value) begin
                  $error("windowed_sample: expected %0d, actual %0d",
                         head_word.value, rsp_ch.windowed_sample);
                  error_count++;
               end
               if (rsp_ch.last_in_frame !== head_word.last) begin
                  $error("last_in_frame: expected %0b, actual %0b",
                         head_word.last, rsp_ch.last_in_frame);
                  error_count++;
               end
               words_checked++;
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(10, 150);
               stall_mode   = $urandom_range(0, 2);
            end else begin
               stretch_left--;
            end
            case (stall_mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, windowed_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.sample      <= '0;
      req_ch.frame_start <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_types();
      test_special_cases();
      test_backpressure();
      test_random_frames();
      drain_results();
      repeat (END_SETTLE) @(posedge clock);
      $display("Run covered %0d sample words over %0d register settings, all four window types,",
               items_sent, settings_count);
      $display("frame wrap, clamped and shrunk half lengths; %0d results checked, %0d mismatches",
               words_checked, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
